// ===== hdl/jobf_pkg.sv =====
// Package with the character codes and byte classification shared by the object framer.
package jobf_pkg;

    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic is_open;
        logic is_close;
        logic is_quote;
        logic is_bslash;
    } t_byte_class;

    function automatic t_byte_class classify_byte(input logic [7:0] b);
        t_byte_class c;
        c.is_open   = (b == CH_OPEN);
        c.is_close  = (b == CH_CLOSE);
        c.is_quote  = (b == CH_QUOTE);
        c.is_bslash = (b == CH_BSLASH);
        return c;
    endfunction

endpackage

// ===== hdl/jobf_if.sv =====
// Valid/ready request channels for the object framer's byte input and result output.
interface jobf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface jobf_out_if #(
    parameter int START_W = 10,
    parameter int LEN_W   = 11
);
    logic               valid;
    logic               ready;
    logic [START_W-1:0] obj_start;
    logic [LEN_W-1:0]   obj_len;
    logic               saturated;

    modport source (output valid, output obj_start, output obj_len, output saturated,
                    input ready);
    modport sink (input valid, input obj_start, input obj_len, input saturated,
                  output ready);
endinterface

// ===== hdl/jobf_tracker.sv =====
// Brace, quote and escape tracker that holds the framing state and detects object ends.
module jobf_tracker
    import jobf_pkg::*;
#(
    parameter int WINDOW_BYTES = 1024,
    parameter int MAX_DEPTH    = 255,
    parameter int POS_W        = 10,
    parameter int LEN_W        = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_byte_class       i_class,
    output logic              o_emit,
    output logic [POS_W-1:0]  o_start,
    output logic [LEN_W-1:0]  o_len,
    output logic              o_sat
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    logic               r_hunting;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_quotes;
    logic               r_escape;
    logic [LEN_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_open_off;
    logic               r_sat;

    logic               n_hunting;
    logic [DEPTH_W-1:0] n_depth;
    logic               n_quotes;
    logic               n_escape;
    logic [LEN_W-1:0]   n_pos;
    logic [POS_W-1:0]   n_open_off;
    logic               n_sat;

    logic               pos_over;
    logic [POS_W-1:0]   off;
    logic               sat_now;
    logic [DEPTH_W-1:0] depth_dec;
    logic               emit;

    always_comb begin
        pos_over  = (r_pos > LEN_W'(WINDOW_BYTES - 1));
        off       = pos_over ? POS_W'(WINDOW_BYTES - 1) : r_pos[POS_W-1:0];
        sat_now   = r_sat | pos_over;
        depth_dec = (r_depth != '0) ? r_depth - DEPTH_W'(1) : r_depth;

        n_hunting  = r_hunting;
        n_depth    = r_depth;
        n_quotes   = r_quotes;
        n_escape   = r_escape;
        n_pos      = LEN_W'(off) + LEN_W'(1);
        n_open_off = r_open_off;
        n_sat      = sat_now;
        emit       = 1'b0;

        if (r_hunting) begin
            if (i_class.is_open) begin
                n_hunting  = 1'b0;
                n_depth    = DEPTH_W'(1);
                n_quotes   = 1'b0;
                n_escape   = 1'b0;
                n_open_off = off;
            end
        end else if (r_escape) begin
            n_escape = 1'b0;
        end else if (i_class.is_bslash) begin
            n_escape = 1'b1;
        end else if (i_class.is_quote) begin
            n_quotes = ~r_quotes;
        end else if (r_quotes) begin
            n_quotes = r_quotes;
        end else if (i_class.is_open) begin
            if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                n_sat = 1'b1;
            end else begin
                n_depth = r_depth + DEPTH_W'(1);
            end
        end else if (i_class.is_close) begin
            if (depth_dec == '0) begin
                emit       = 1'b1;
                n_hunting  = 1'b1;
                n_depth    = '0;
                n_quotes   = 1'b0;
                n_escape   = 1'b0;
                n_pos      = '0;
                n_open_off = '0;
                n_sat      = 1'b0;
            end else begin
                n_depth = depth_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting  <= 1'b1;
            r_depth    <= '0;
            r_quotes   <= 1'b0;
            r_escape   <= 1'b0;
            r_pos      <= '0;
            r_open_off <= '0;
            r_sat      <= 1'b0;
        end else if (i_step) begin
            r_hunting  <= n_hunting;
            r_depth    <= n_depth;
            r_quotes   <= n_quotes;
            r_escape   <= n_escape;
            r_pos      <= n_pos;
            r_open_off <= n_open_off;
            r_sat      <= n_sat;
        end
    end

    assign o_emit  = i_step & emit;
    assign o_start = r_open_off;
    assign o_len   = LEN_W'(off) - LEN_W'(r_open_off) + LEN_W'(1);
    assign o_sat   = sat_now;

    a_hunt_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunting |-> (r_depth == '0))
        else $error("Depth is nonzero while hunting.");

    a_depth_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("Brace depth went past its limit.");

    a_pos_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LEN_W'(WINDOW_BYTES))
        else $error("Byte position went past the window size.");

    a_emit_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_hunting && r_pos == '0 && !r_sat))
        else $error("State was not cleared after an object closed.");

    a_emit_in_object: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (!r_hunting && !r_quotes && !r_escape && i_class.is_close))
        else $error("Object end seen outside a closing brace in an open object.");

endmodule

// ===== hdl/json_object_boundary_finder.sv =====
// Top level of the JSON object framer: input register, framing tracker and result register.
// One byte is accepted per cycle while no result waits unaccepted. A registered byte is
// classified and run through the brace, quote and escape tracker once the tracker may
// advance, and a closing brace that brings the depth back to zero loads a result register,
// so a result is valid after the byte that ends the object has passed the input register
// and the tracker. While a result waits the tracker holds, and the byte input stalls as
// soon as its register holds a byte. Offsets count from the first byte after the previous
// object; position and depth stop at their limits and set the next result's saturated flag.
module json_object_boundary_finder
    import jobf_pkg::*;
#(
    parameter int WINDOW_BYTES = 1024,
    parameter int MAX_DEPTH    = 255
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    jobf_in_if.sink  i_in,
    jobf_out_if.source o_out
);

    localparam int POS_W = $clog2(WINDOW_BYTES);
    localparam int LEN_W = $clog2(WINDOW_BYTES + 1);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_start;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_sat;

    logic             advance;
    logic             step;
    logic             emit;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             sat;
    t_byte_class      byte_class;

    assign advance    = ~r_out_valid | o_out.ready;
    assign step       = r_in_valid & advance;
    assign i_in.ready = ~r_in_valid | advance;
    assign byte_class = classify_byte(r_in_byte);

    jobf_tracker #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .MAX_DEPTH    (MAX_DEPTH),
        .POS_W        (POS_W),
        .LEN_W        (LEN_W)
    ) u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_class (byte_class),
        .o_emit  (emit),
        .o_start (start),
        .o_len   (len),
        .o_sat   (sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_start <= start;
            r_out_len   <= len;
            r_out_sat   <= sat;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.obj_start = r_out_start;
    assign o_out.obj_len   = r_out_len;
    assign o_out.saturated = r_out_sat;

endmodule
